FILE: hw/rtl/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants of the pixel cluster centroid / bounding box block.
// ----------------------------------------------------------------------------
package pcc_pkg;

  // number of cluster snapshots buffered between accumulator and divider
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_DIV  = 3'b010,
    BK_HOLD = 3'b100
  } back_state_e;

endpackage

FILE: hw/rtl/pcc_queue.sv
// ----------------------------------------------------------------------------
// pcc_queue
// Small register queue of cluster snapshots between front and back.
// ----------------------------------------------------------------------------
module pcc_queue
  import pcc_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output q_status_t        status_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: hw/rtl/pcc_front.sv
// ----------------------------------------------------------------------------
// pcc_front
// Per-pixel accumulator: sums, count, earliest time and bounding box.
// Pushes a snapshot of the cluster whenever a result is due.
// ----------------------------------------------------------------------------
module pcc_front
  import pcc_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = 256,
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned TIME_BITS  = 16,
  parameter int unsigned CNT_W      = 9,
  parameter int unsigned SUM_W      = 18,
  parameter int unsigned SNAP_W     = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_BITS-1:0] pix_col_i,
  input  logic [COORD_BITS-1:0] pix_row_i,
  input  logic [TIME_BITS-1:0]  pix_time_i,
  input  logic                  last_pixel_i,
  input  q_status_t             q_status_i,
  output logic                  push_o,
  output logic [SNAP_W-1:0]     snap_o
);

  logic                  auto_q;
  logic [SUM_W-1:0]      col_sum_q, col_sum_d, row_sum_q, row_sum_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [TIME_BITS-1:0]  tmin_q, tmin_d;
  logic [COORD_BITS-1:0] left_q, left_d, right_q, right_d;
  logic [COORD_BITS-1:0] bot_q, bot_d, top_q, top_d;
  logic                  drop_q, drop_d;
  logic                  accept, room;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign room       = (cnt_q < CNT_W'(MAX_PIXELS));
  assign push_o     = accept && (last_pixel_i || auto_q);

  // updated cluster state including the current pixel
  always_comb begin
    col_sum_d = col_sum_q;
    row_sum_d = row_sum_q;
    cnt_d     = cnt_q;
    tmin_d    = tmin_q;
    left_d    = left_q;
    right_d   = right_q;
    bot_d     = bot_q;
    top_d     = top_q;
    drop_d    = drop_q;
    if (room) begin
      col_sum_d = col_sum_q + SUM_W'(pix_col_i);
      row_sum_d = row_sum_q + SUM_W'(pix_row_i);
      cnt_d     = cnt_q + CNT_W'(1);
      if (pix_time_i < tmin_q) tmin_d  = pix_time_i;
      if (pix_col_i < left_q)  left_d  = pix_col_i;
      if (pix_col_i > right_q) right_d = pix_col_i;
      if (pix_row_i < bot_q)   bot_d   = pix_row_i;
      if (pix_row_i > top_q)   top_d   = pix_row_i;
    end else begin
      drop_d = 1'b1;
    end
  end

  assign snap_o = {last_pixel_i, drop_d, cnt_d, col_sum_d, row_sum_d, tmin_d,
                   left_d, right_d, bot_d, top_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_q    <= 1'b0;
      col_sum_q <= '0;
      row_sum_q <= '0;
      cnt_q     <= '0;
      tmin_q    <= '1;
      left_q    <= '1;
      right_q   <= '0;
      bot_q     <= '1;
      top_q     <= '0;
      drop_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        auto_q <= cfg_wdata_i;
      end
      if (accept) begin
        if (last_pixel_i) begin
          col_sum_q <= '0;
          row_sum_q <= '0;
          cnt_q     <= '0;
          tmin_q    <= '1;
          left_q    <= '1;
          right_q   <= '0;
          bot_q     <= '1;
          top_q     <= '0;
          drop_q    <= 1'b0;
        end else begin
          col_sum_q <= col_sum_d;
          row_sum_q <= row_sum_d;
          cnt_q     <= cnt_d;
          tmin_q    <= tmin_d;
          left_q    <= left_d;
          right_q   <= right_d;
          bot_q     <= bot_d;
          top_q     <= top_d;
          drop_q    <= drop_d;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/pcc_back.sv
// ----------------------------------------------------------------------------
// pcc_back
// Centroid divider and result register. Two restoring dividers share one
// step counter and retire one quotient bit each per cycle.
// ----------------------------------------------------------------------------
module pcc_back
  import pcc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned TIME_BITS  = 16,
  parameter int unsigned FRAC_BITS  = 8,
  parameter int unsigned CNT_W      = 9,
  parameter int unsigned SUM_W      = 18,
  parameter int unsigned SNAP_W     = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  q_status_t                       q_status_i,
  input  logic [SNAP_W-1:0]               snap_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [COORD_BITS+FRAC_BITS-1:0] centroid_col_o,
  output logic [COORD_BITS+FRAC_BITS-1:0] centroid_row_o,
  output logic [TIME_BITS-1:0]            earliest_time_o,
  output logic [COORD_BITS-1:0]           box_left_o,
  output logic [COORD_BITS-1:0]           box_right_o,
  output logic [COORD_BITS-1:0]           box_bottom_o,
  output logic [COORD_BITS-1:0]           box_top_o,
  output logic [COORD_BITS:0]             box_width_o,
  output logic [COORD_BITS:0]             box_height_o,
  output logic [CNT_W-1:0]                multiplicity_o,
  output logic                            cluster_done_o,
  output logic                            overflow_o
);

  localparam int unsigned DVD_W  = SUM_W + FRAC_BITS;
  localparam int unsigned CEN_W  = COORD_BITS + FRAC_BITS;
  localparam int unsigned STEP_W = $clog2(DVD_W);
  localparam logic [CEN_W-1:0] HALF = CEN_W'(1) << (FRAC_BITS - 1);

  // snapshot fields
  logic                  s_done, s_drop;
  logic [CNT_W-1:0]      s_cnt;
  logic [SUM_W-1:0]      s_csum, s_rsum;
  logic [TIME_BITS-1:0]  s_tmin;
  logic [COORD_BITS-1:0] s_left, s_right, s_bot, s_top;

  assign {s_done, s_drop, s_cnt, s_csum, s_rsum, s_tmin,
          s_left, s_right, s_bot, s_top} = snap_i;

  back_state_e           state_q, state_d;
  logic [STEP_W-1:0]     step_q;
  logic [DVD_W-1:0]      dvc_q, dvr_q;
  logic [CNT_W-1:0]      remc_q, remr_q, div_q;
  logic                  done_q, drop_q;
  logic [TIME_BITS-1:0]  tmin_q;
  logic [COORD_BITS-1:0] left_q, right_q, bot_q, top_q;
  logic                  out_valid_q;

  logic [CNT_W:0]        shc, shr;
  logic                  gec, ger;
  logic [CNT_W-1:0]      remc_n, remr_n;
  logic                  load_out;

  assign shc    = {remc_q, dvc_q[DVD_W-1]};
  assign shr    = {remr_q, dvr_q[DVD_W-1]};
  assign gec    = (shc >= {1'b0, div_q});
  assign ger    = (shr >= {1'b0, div_q});
  assign remc_n = gec ? CNT_W'(shc - {1'b0, div_q}) : CNT_W'(shc);
  assign remr_n = ger ? CNT_W'(shr - {1'b0, div_q}) : CNT_W'(shr);

  assign pop_o    = (state_q == BK_IDLE) && !q_status_i.empty;
  assign load_out = (state_q == BK_HOLD) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (!q_status_i.empty) state_d = BK_DIV;
      BK_DIV:  if (step_q == STEP_W'(DVD_W - 1)) state_d = BK_HOLD;
      BK_HOLD: if (load_out) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        step_q <= '0;
      end else if (state_q == BK_DIV) begin
        step_q <= step_q + STEP_W'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // divider datapath; quotient bits shift in behind the dividend
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      dvc_q  <= {s_csum, FRAC_BITS'(0)};
      dvr_q  <= {s_rsum, FRAC_BITS'(0)};
      remc_q <= '0;
      remr_q <= '0;
      div_q  <= s_cnt;
      done_q <= s_done;
      drop_q <= s_drop;
      tmin_q <= s_tmin;
      left_q <= s_left;
      right_q <= s_right;
      bot_q  <= s_bot;
      top_q  <= s_top;
    end else if (state_q == BK_DIV) begin
      dvc_q  <= {dvc_q[DVD_W-2:0], gec};
      dvr_q  <= {dvr_q[DVD_W-2:0], ger};
      remc_q <= remc_n;
      remr_q <= remr_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      centroid_col_o  <= CEN_W'(dvc_q) + HALF;
      centroid_row_o  <= CEN_W'(dvr_q) + HALF;
      earliest_time_o <= tmin_q;
      box_left_o      <= left_q;
      box_right_o     <= right_q;
      box_bottom_o    <= bot_q;
      box_top_o       <= top_q;
      box_width_o     <= {1'b0, right_q} - {1'b0, left_q} + (COORD_BITS+1)'(1);
      box_height_o    <= {1'b0, top_q} - {1'b0, bot_q} + (COORD_BITS+1)'(1);
      multiplicity_o  <= div_q;
      cluster_done_o  <= done_q;
      overflow_o      <= drop_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/pixel_cluster_centroid_bbox.sv
// ----------------------------------------------------------------------------
// pixel_cluster_centroid_bbox
// Hit cluster centroid and bounding box.
//
// Input channel (in_valid_i/in_ready_o) carries one hit pixel per item; the
// last_pixel_i mark closes the cluster. Output channel (out_valid_o/
// out_ready_i) carries one result item per closed cluster, or per pixel when
// auto_update (cfg_we_i/cfg_wdata_i) is set.
// Pixels are accumulated at one per cycle while the queue is not full.
// A result goes through a queue of QUEUE_DEPTH snapshots to a bit-serial
// divider that retires one quotient bit per cycle; the divider takes the
// next snapshot only after its result has been loaded into the result
// register that drives out_valid_o. Pixels that produce no result never
// wait on the divider unless the queue is full.
// If the receiver stalls, the result register holds, the divider waits with
// its finished result, the queue fills and then in_ready_o drops.
// Reset clears the cluster, the queue, the divider and auto_update.
// ----------------------------------------------------------------------------
module pixel_cluster_centroid_bbox
  import pcc_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = 256,
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned TIME_BITS  = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [COORD_BITS-1:0]           pix_col_i,
  input  logic [COORD_BITS-1:0]           pix_row_i,
  input  logic [TIME_BITS-1:0]            pix_time_i,
  input  logic                            last_pixel_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [COORD_BITS+FRAC_BITS-1:0] centroid_col_o,
  output logic [COORD_BITS+FRAC_BITS-1:0] centroid_row_o,
  output logic [TIME_BITS-1:0]            earliest_time_o,
  output logic [COORD_BITS-1:0]           box_left_o,
  output logic [COORD_BITS-1:0]           box_right_o,
  output logic [COORD_BITS-1:0]           box_bottom_o,
  output logic [COORD_BITS-1:0]           box_top_o,
  output logic [COORD_BITS:0]             box_width_o,
  output logic [COORD_BITS:0]             box_height_o,
  output logic [$clog2(MAX_PIXELS+1)-1:0] multiplicity_o,
  output logic                            cluster_done_o,
  output logic                            overflow_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned SUM_W  = COORD_BITS + $clog2(MAX_PIXELS);
  localparam int unsigned SNAP_W = 2 + CNT_W + 2 * SUM_W + TIME_BITS + 4 * COORD_BITS;

  q_status_t         q_status;
  logic              push, pop;
  logic [SNAP_W-1:0] snap_in, snap_out;

  pcc_front #(
    .MAX_PIXELS (MAX_PIXELS),
    .COORD_BITS (COORD_BITS),
    .TIME_BITS  (TIME_BITS),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W),
    .SNAP_W     (SNAP_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pix_col_i    (pix_col_i),
    .pix_row_i    (pix_row_i),
    .pix_time_i   (pix_time_i),
    .last_pixel_i (last_pixel_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .snap_o       (snap_in)
  );

  pcc_queue #(
    .WIDTH (SNAP_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (snap_in),
    .pop_i    (pop),
    .rdata_o  (snap_out),
    .status_o (q_status)
  );

  pcc_back #(
    .COORD_BITS (COORD_BITS),
    .TIME_BITS  (TIME_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W),
    .SNAP_W     (SNAP_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_status_i      (q_status),
    .snap_i          (snap_out),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .centroid_col_o  (centroid_col_o),
    .centroid_row_o  (centroid_row_o),
    .earliest_time_o (earliest_time_o),
    .box_left_o      (box_left_o),
    .box_right_o     (box_right_o),
    .box_bottom_o    (box_bottom_o),
    .box_top_o       (box_top_o),
    .box_width_o     (box_width_o),
    .box_height_o    (box_height_o),
    .multiplicity_o  (multiplicity_o),
    .cluster_done_o  (cluster_done_o),
    .overflow_o      (overflow_o)
  );

endmodule

FILE: hw/rtl/pcc_checker.sv
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level checks of the cluster centroid block, bound to the top level.
// ----------------------------------------------------------------------------
module pcc_checker #(
  parameter int unsigned MAX_PIXELS = 256,
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned FRAC_BITS  = 8
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [COORD_BITS+FRAC_BITS-1:0] centroid_col_o,
  input logic [COORD_BITS+FRAC_BITS-1:0] centroid_row_o,
  input logic [COORD_BITS-1:0]           box_left_o,
  input logic [COORD_BITS-1:0]           box_right_o,
  input logic [COORD_BITS:0]             box_width_o,
  input logic [$clog2(MAX_PIXELS+1)-1:0] multiplicity_o
);

  localparam int unsigned CEN_W = COORD_BITS + FRAC_BITS;
  localparam logic [CEN_W-1:0] HALF = CEN_W'(1) << (FRAC_BITS - 1);

  logic [CEN_W-1:0] lo_col, hi_col;

  assign lo_col = {box_left_o, FRAC_BITS'(0)} + HALF;
  assign hi_col = {box_right_o, FRAC_BITS'(0)} + HALF;

  // a stalled result keeps its centroid
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(centroid_col_o)
      && $stable(centroid_row_o))
    else $error("result changed while stalled");

  a_mult: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> multiplicity_o != '0)
    else $error("result with no pixels");

  a_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> box_width_o ==
      ({1'b0, box_right_o} - {1'b0, box_left_o} + (COORD_BITS+1)'(1)))
    else $error("box width does not match edges");

  // mean column lies inside the box
  a_inbox: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> centroid_col_o >= lo_col && centroid_col_o <= hi_col)
    else $error("column centroid outside box");

endmodule

bind pixel_cluster_centroid_bbox pcc_checker #(
  .MAX_PIXELS (MAX_PIXELS),
  .COORD_BITS (COORD_BITS),
  .FRAC_BITS  (FRAC_BITS)
) u_pcc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .centroid_col_o (centroid_col_o),
  .centroid_row_o (centroid_row_o),
  .box_left_o     (box_left_o),
  .box_right_o    (box_right_o),
  .box_width_o    (box_width_o),
  .multiplicity_o (multiplicity_o)
);
